>>> rtl/core/point_crop_box_filter_assert.svh
// Assertion macros for the point crop-box filter checker.
`ifndef POINT_CROP_BOX_FILTER_ASSERT_SVH
`define POINT_CROP_BOX_FILTER_ASSERT_SVH

// Property checked only outside reset.
`define PCBF_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define PCBF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/core/pcbf_pkg.sv
// ----------------------------------------------------------------------------
// pcbf_pkg
// Shared widths, reset values, register indexes and control types of the
// point crop-box filter.
// ----------------------------------------------------------------------------
package pcbf_pkg;

    // field widths
    localparam int COORD_W    = 32;
    localparam int INTEN_W    = 16;
    localparam int SLOT_W     = 16;
    localparam int FEAT_W     = 17;
    localparam int CNT_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // stream widths
    localparam int S_TDATA_W  = 112;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 136;

    // slot limits
    localparam int DEFAULT_SLOT_LIMIT = 65536;
    localparam int SLOT_CAP           = 65536;

    // Q16 one
    localparam logic [FEAT_W-1:0] FEATURE_ONE = 17'h10000;

    // divider: one quotient bit per step
    localparam int DIV_STEPS = 16;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // register reset values
    localparam logic signed [COORD_W-1:0] RST_X_MIN = -32'sd51200;
    localparam logic signed [COORD_W-1:0] RST_X_MAX =  32'sd51200;
    localparam logic signed [COORD_W-1:0] RST_Y_MIN = -32'sd51200;
    localparam logic signed [COORD_W-1:0] RST_Y_MAX =  32'sd51200;
    localparam logic signed [COORD_W-1:0] RST_Z_MIN = -32'sd5000;
    localparam logic signed [COORD_W-1:0] RST_Z_MAX =  32'sd3000;
    localparam logic [INTEN_W-1:0]        RST_THRESH = 16'd255;
    localparam logic [CNT_W-1:0]          RST_MAX_POINTS = 17'h10000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_MIN      = 3'd0,
        REG_X_MAX      = 3'd1,
        REG_Y_MIN      = 3'd2,
        REG_Y_MAX      = 3'd3,
        REG_Z_MIN      = 3'd4,
        REG_Z_MAX      = 3'd5,
        REG_THRESH     = 3'd6,
        REG_MAX_POINTS = 3'd7
    } t_reg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic eval;
        logic step_div;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic keep;
        logic out_busy;
    } t_sts;

endpackage

>>> rtl/core/point_crop_box_filter.sv
// ----------------------------------------------------------------------------
// point_crop_box_filter
// Drops lidar points outside a box, numbers kept points per cloud and
// normalizes their intensity to a Q16 feature.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata x,y,z,intensity; tuser first,invalid
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata slot,x,y,z,feature
//  cfg       in         i_cfg_we                     i_cfg_index, i_cfg_data
//
//  A dropped point goes through accept and box test; a kept point goes through
//  accept, box test, the one-bit-per-cycle intensity divider and the output
//  load, which puts its result on m_axis.
//  The output register lets the next point be accepted while a result waits;
//  a stalled m_axis holds the block only when a second result is ready.
//  Reset is synchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module point_crop_box_filter #(
    parameter int SLOT_LIMIT = pcbf_pkg::DEFAULT_SLOT_LIMIT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcbf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x[31:0], y[63:32], z[95:64], intensity[111:96]
    input  logic [pcbf_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // first_of_cloud[0], point_invalid[1]
    input  logic [pcbf_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // slot_index[15:0], x_out[47:16], y_out[79:48], z_out[111:80],
    // feature[128:112], zero[135:129]
    output logic [pcbf_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import pcbf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    pcbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pcbf_datapath #(
        .SLOT_LIMIT (SLOT_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

>>> rtl/core/pcbf_ctrl.sv
// ----------------------------------------------------------------------------
// pcbf_ctrl
// Sequencer: accept, judge, divide, hand the result to the output register.
// ----------------------------------------------------------------------------
module pcbf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pcbf_pkg::t_sts i_sts,
    output pcbf_pkg::t_cmd o_cmd
);
    import pcbf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.keep ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                o_cmd.step_div = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait until the output register can take the result
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

endmodule

>>> rtl/core/pcbf_datapath.sv
// ----------------------------------------------------------------------------
// pcbf_datapath
// Config registers, point capture, box test, slot counter, bit-serial
// intensity divider and output register.
// ----------------------------------------------------------------------------
module pcbf_datapath #(
    parameter int SLOT_LIMIT = pcbf_pkg::DEFAULT_SLOT_LIMIT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcbf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [pcbf_pkg::S_TDATA_W-1:0]      i_in_data,
    input  logic [pcbf_pkg::S_TUSER_W-1:0]      i_in_user,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [pcbf_pkg::M_TDATA_W-1:0]      o_out_data,
    input  pcbf_pkg::t_cmd                      i_cmd,
    output pcbf_pkg::t_sts                      o_sts
);
    import pcbf_pkg::*;

    localparam int LIM_CAP = (SLOT_LIMIT < SLOT_CAP) ? SLOT_LIMIT : SLOT_CAP;
    localparam logic [CNT_W-1:0] LIM_CAP_V = CNT_W'(LIM_CAP);
    localparam int PAD_W = M_TDATA_W - SLOT_W - 3 * COORD_W - FEAT_W;

    logic signed [COORD_W-1:0] r_x_min, r_x_max, r_y_min, r_y_max, r_z_min, r_z_max;
    logic [INTEN_W-1:0]        r_thresh;
    logic [CNT_W-1:0]          r_max_points;

    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic                      r_invalid;
    logic [INTEN_W-1:0]        r_intensity;

    logic [CNT_W-1:0]          r_slots;
    logic [SLOT_W-1:0]         r_slot_idx;
    logic [INTEN_W-1:0]        r_rem;
    logic [INTEN_W-1:0]        r_quo;
    logic                      r_sat;

    logic                      r_out_valid;
    logic [M_TDATA_W-1:0]      r_out_data;

    logic [CNT_W-1:0]          w_limit;
    logic                      w_keep;
    logic [INTEN_W:0]          w_shift;
    logic [INTEN_W:0]          w_diff;
    logic                      w_ge;
    logic [FEAT_W-1:0]         w_feat;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min      <= RST_X_MIN;
            r_x_max      <= RST_X_MAX;
            r_y_min      <= RST_Y_MIN;
            r_y_max      <= RST_Y_MAX;
            r_z_min      <= RST_Z_MIN;
            r_z_max      <= RST_Z_MAX;
            r_thresh     <= RST_THRESH;
            r_max_points <= RST_MAX_POINTS;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_X_MIN:      r_x_min      <= i_cfg_data;
                REG_X_MAX:      r_x_max      <= i_cfg_data;
                REG_Y_MIN:      r_y_min      <= i_cfg_data;
                REG_Y_MAX:      r_y_max      <= i_cfg_data;
                REG_Z_MIN:      r_z_min      <= i_cfg_data;
                REG_Z_MAX:      r_z_max      <= i_cfg_data;
                REG_THRESH:     r_thresh     <= i_cfg_data[INTEN_W-1:0];
                REG_MAX_POINTS: r_max_points <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // point capture; tdata = x, y, z, intensity; tuser = first, invalid
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x         <= i_in_data[COORD_W-1:0];
            r_y         <= i_in_data[2*COORD_W-1:COORD_W];
            r_z         <= i_in_data[3*COORD_W-1:2*COORD_W];
            r_intensity <= i_in_data[3*COORD_W+INTEN_W-1:3*COORD_W];
            r_invalid   <= i_in_user[1];
        end
    end

    // box test and slot check
    assign w_limit = (r_max_points < LIM_CAP_V) ? r_max_points : LIM_CAP_V;
    assign w_keep  = !r_invalid
                     && (r_x >= r_x_min) && (r_x < r_x_max)
                     && (r_y >= r_y_min) && (r_y < r_y_max)
                     && (r_z >= r_z_min) && (r_z < r_z_max)
                     && (r_slots < w_limit);

    // slot counter, cleared by the first point of a cloud
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else if (i_cmd.load_in && i_in_user[0]) begin
            r_slots <= '0;
        end else if (i_cmd.eval && w_keep) begin
            r_slots <= r_slots + 1'b1;
        end
    end

    // restoring divider step; remainder stays below the threshold
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_thresh});
    assign w_diff  = w_shift - {1'b0, r_thresh};

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_slot_idx <= r_slots[SLOT_W-1:0];
            r_rem      <= r_intensity;
            r_quo      <= '0;
            // intensity at or above threshold (or zero threshold) saturates
            r_sat      <= (r_intensity >= r_thresh);
        end else if (i_cmd.step_div) begin
            r_rem <= w_ge ? w_diff[INTEN_W-1:0] : w_shift[INTEN_W-1:0];
            r_quo <= {r_quo[INTEN_W-2:0], w_ge};
        end
    end

    assign w_feat = r_sat ? FEATURE_ONE : {1'b0, r_quo};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {{PAD_W{1'b0}}, w_feat, r_z, r_y, r_x, r_slot_idx};
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_sts.keep     = w_keep;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

endmodule

>>> rtl/core/pcbf_checker.sv
// ----------------------------------------------------------------------------
// pcbf_checker
// Port-level checks of the point crop-box filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_crop_box_filter_assert.svh"

module pcbf_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [pcbf_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import pcbf_pkg::*;

    // reset empties the output register
    `PCBF_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // a stalled result holds
    `PCBF_ASSERT_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // one point at a time: the box test follows every transaction
    `PCBF_ASSERT_RUN(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready right after accept")

    // feature never exceeds 1.0 and the padding stays zero
    `PCBF_ASSERT_RUN(a_feature_range, m_axis_tvalid |-> (m_axis_tdata[128:112] <= FEATURE_ONE) && (m_axis_tdata[135:129] == 7'd0), "feature out of range")

endmodule

bind point_crop_box_filter pcbf_checker u_pcbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/point_crop_box_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_crop_box_filter_tb
// Self-checking bench for the crop-box filter. A driver streams lidar points
// from a queue, a behavioral predictor works out which points survive the box
// and slot limit and what slot and Q16 feature each one gets, and a monitor
// checks every output transaction against the oldest prediction. The run goes
// through a directed pass and then several random box settings, with random
// back-pressure on both streams.
// ----------------------------------------------------------------------------
module point_crop_box_filter_tb;
    import pcbf_pkg::*;

    localparam int SLOT_LIMIT    = DEFAULT_SLOT_LIMIT;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam logic [31:0] INT_MIN_W = 32'h8000_0000;
    localparam logic [31:0] INT_MAX_W = 32'h7FFF_FFFF;

    // one lidar point as offered on s_axis
    typedef struct packed {
        logic        first;
        logic        invalid;
        logic [15:0] intensity;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_point;

    // one kept point, laid out as the low bits of m_axis_tdata
    typedef struct packed {
        logic [FEAT_W-1:0] feature;
        logic [31:0]       z;
        logic [31:0]       y;
        logic [31:0]       x;
        logic [SLOT_W-1:0] slot;
    } t_kept;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // x[31:0], y[63:32], z[95:64], intensity[111:96]
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    // first_of_cloud[0], point_invalid[1]
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // slot_index[15:0], x_out[47:16], y_out[79:48], z_out[111:80],
    // feature[128:112], zero[135:129]
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // predictor copy of the registers and the slot counter
    int                 box_lo [3];
    int                 box_hi [3];
    logic [INTEN_W-1:0] thresh_reg;
    logic [CNT_W-1:0]   max_pts_reg;
    logic [CNT_W-1:0]   slots_used;

    t_point point_queue [$];
    t_kept  kept_queue [$];
    t_point offered_pt;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int errors       = 0;
    int cycle_cnt    = 0;

    point_crop_box_filter #(
        .SLOT_LIMIT(SLOT_LIMIT)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Box test, slot numbering and feature of one accepted point.
    function automatic void predict_kept(input t_point p);
        logic [31:0]      coord [3];
        int               limit;
        logic [31:0]      quot;
        t_kept            k;
        coord[0] = p.x;
        coord[1] = p.y;
        coord[2] = p.z;
        // a new cloud restarts numbering even if its first point is dropped
        if (p.first) slots_used = '0;
        if (p.invalid) return;
        for (int a = 0; a < 3; a++) begin
            if ($signed(coord[a]) < box_lo[a] || $signed(coord[a]) >= box_hi[a]) return;
        end
        limit = int'(max_pts_reg);
        if (limit > SLOT_LIMIT) limit = SLOT_LIMIT;
        if (limit > SLOT_CAP) limit = SLOT_CAP;
        if (int'(slots_used) >= limit) return;
        if (thresh_reg == '0) begin
            k.feature = FEATURE_ONE;
        end else begin
            quot = {p.intensity, 16'h0000} / {16'h0000, thresh_reg};
            k.feature = (quot > 32'h0001_0000) ? FEATURE_ONE : quot[FEAT_W-1:0];
        end
        k.slot = slots_used[SLOT_W-1:0];
        k.x = p.x;
        k.y = p.y;
        k.z = p.z;
        slots_used = slots_used + 1'b1;
        kept_queue = {kept_queue, k};
    endfunction

    function automatic void add_point(input logic first_pt, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z,
                                      input logic invalid, input logic [15:0] inten);
        t_point p;
        p.first = first_pt;
        p.invalid = invalid;
        p.intensity = inten;
        p.x = x;
        p.y = y;
        p.z = z;
        point_queue = {point_queue, p};
    endfunction

    // Coordinate for one axis: mostly inside the box, often on its edges.
    function automatic logic [31:0] pick_coord(input int lo, input int hi);
        int unsigned      roll;
        longint           span;
        longint unsigned  rnd;
        roll = $urandom_range(99);
        span = longint'(hi) - longint'(lo);
        rnd = {$urandom, $urandom};
        if (roll < 6) return $urandom;
        if (span <= 0) return (roll % 3 == 0) ? lo : (roll % 3 == 1) ? hi : $urandom;
        if (roll < 14) return lo;
        if (roll < 20) return hi - 1;
        if (roll < 25) return hi;
        if (roll < 30) return lo - 1;
        return 32'(longint'(lo) + longint'(rnd % longint'(span)));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Register write, mirrored into the predictor. Caller lowers the enable.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_X_MIN:      box_lo[0] = val;
            REG_X_MAX:      box_hi[0] = val;
            REG_Y_MIN:      box_lo[1] = val;
            REG_Y_MAX:      box_hi[1] = val;
            REG_Z_MIN:      box_lo[2] = val;
            REG_Z_MAX:      box_hi[2] = val;
            REG_THRESH:     thresh_reg = val[INTEN_W-1:0];
            REG_MAX_POINTS: max_pts_reg = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every point went in and every kept point came out.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (point_queue.size() != 0 || s_axis_tvalid || kept_queue.size() != 0);
    endtask

    // Full register set, written only once the block has gone quiet.
    task automatic load_settings(input logic [31:0] xl, xh, yl, yh, zl, zh,
                                 input logic [31:0] thr_w, maxp_w);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(REG_X_MIN, xl);
        write_reg(REG_X_MAX, xh);
        write_reg(REG_Y_MIN, yl);
        write_reg(REG_Y_MAX, yh);
        write_reg(REG_Z_MIN, zl);
        write_reg(REG_Z_MAX, zh);
        write_reg(REG_THRESH, thr_w);
        write_reg(REG_MAX_POINTS, maxp_w);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Point driver: predicts at acceptance, then offers the next point.
    always @(posedge i_clk) begin : drive_points
        logic slot_free;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            slot_free = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_kept(offered_pt);
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (point_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered_pt = point_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered_pt.intensity, offered_pt.z,
                                      offered_pt.y, offered_pt.x};
                    s_axis_tuser  <= {offered_pt.invalid, offered_pt.first};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random and long back-pressure.
    always @(posedge i_clk) begin : watch_results
        t_kept got;
        t_kept want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_kept)-1:0];
                if (kept_queue.size() == 0) begin
                    $display("%0t: result with no kept point pending, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = kept_queue.pop_front();
                    check_field("slot_index", 32'(want.slot), 32'(got.slot));
                    check_field("x_out", want.x, got.x);
                    check_field("y_out", want.y, got.y);
                    check_field("z_out", want.z, got.z);
                    check_field("feature", 32'(want.feature), 32'(got.feature));
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d kept points still pending", $time, kept_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : run_phases
        int              lo [3];
        int              hi [3];
        logic [31:0]     thr_word;
        logic [31:0]     maxp_word;
        logic [15:0]     inten;
        logic            first_pt;
        int              cloud_left;
        int unsigned     roll;
        int              c;
        int              hw;
        box_lo[0]   = RST_X_MIN;
        box_hi[0]   = RST_X_MAX;
        box_lo[1]   = RST_Y_MIN;
        box_hi[1]   = RST_Y_MAX;
        box_lo[2]   = RST_Z_MIN;
        box_hi[2]   = RST_Z_MAX;
        thresh_reg  = RST_THRESH;
        max_pts_reg = RST_MAX_POINTS;
        slots_used  = '0;
        cloud_left  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        src_idle_pct = 33;
        snk_idle_pct = 46;

        // reset box: corners, edges just outside, invalid, feature extremes
        add_point(1'b1, -51200, -51200, -5000, 1'b0, 16'd255);
        add_point(1'b0, 51199, 51199, 2999, 1'b0, 16'd0);
        add_point(1'b0, 51200, 0, 0, 1'b0, 16'd10);
        add_point(1'b0, -51201, 0, 0, 1'b0, 16'd10);
        add_point(1'b0, 0, 0, 3000, 1'b0, 16'd10);
        add_point(1'b0, 0, 51200, 0, 1'b0, 16'd10);
        add_point(1'b0, 0, 0, 0, 1'b1, 16'd10);
        add_point(1'b0, INT_MIN_W, INT_MAX_W, 0, 1'b0, 16'd10);
        add_point(1'b0, 0, 0, 0, 1'b0, 16'hFFFF);
        add_point(1'b0, 1, -1, -1, 1'b0, 16'd127);

        // full-range box, two slots per cloud, threshold of one
        load_settings(INT_MIN_W, INT_MAX_W, INT_MIN_W, INT_MAX_W, INT_MIN_W, INT_MAX_W,
                      32'd1, 32'd2);
        add_point(1'b1, INT_MIN_W, INT_MIN_W, INT_MIN_W, 1'b0, 16'd0);
        add_point(1'b0, INT_MAX_W - 1, INT_MAX_W - 1, INT_MAX_W - 1, 1'b0, 16'd1);
        add_point(1'b0, 0, 0, 0, 1'b0, 16'd5);
        add_point(1'b1, INT_MAX_W, 0, 0, 1'b0, 16'd5);
        add_point(1'b0, 5, 5, 5, 1'b0, 16'hFFFF);

        // empty box on x and y; wide writes get truncated
        load_settings(100, 100, 10, -10, -5000, 3000, 32'h0001_0000, 32'h0003_FFFF);
        add_point(1'b1, 100, 0, 0, 1'b0, 16'd7);
        add_point(1'b0, 99, 0, 0, 1'b0, 16'd7);

        // zero threshold saturates every feature
        load_settings(-1000, 1000, -1000, 1000, -1000, 1000, 32'h0001_0000, 32'd3);
        add_point(1'b1, 0, 0, 0, 1'b0, 16'd0);
        add_point(1'b0, 999, -1000, 999, 1'b0, 16'd40000);

        // slot limit truncated to zero keeps nothing
        load_settings(-1000, 1000, -1000, 1000, -1000, 1000, 32'd65535, 32'h0002_0000);
        add_point(1'b1, 0, 0, 0, 1'b0, 16'hFFFF);
        add_point(1'b0, 1, 1, 1, 1'b0, 16'd1);

        // random settings, three chunks of points each
        for (int ph = 0; ph < 9; ph++) begin
            for (int a = 0; a < 3; a++) begin
                roll = $urandom_range(19);
                if (roll < 2) begin
                    lo[a] = int'(INT_MIN_W);
                    hi[a] = int'(INT_MAX_W);
                end else if (roll == 2) begin
                    lo[a] = $urandom;
                    hi[a] = lo[a] - int'($urandom_range(5));
                end else begin
                    c = int'($urandom_range(200000)) - 100000;
                    hw = $urandom_range(1, 60000);
                    lo[a] = c - hw;
                    hi[a] = c + hw + int'($urandom_range(1));
                end
            end
            roll = $urandom_range(9);
            case (roll)
                0:       thr_word = 32'd1;
                1:       thr_word = 32'h0000_FFFF;
                2:       thr_word = $urandom_range(1, 255);
                default: thr_word = {16'($urandom), 16'($urandom_range(1, 65535))};
            endcase
            roll = $urandom_range(19);
            case (roll)
                0:       maxp_word = 32'd1;
                1:       maxp_word = 32'h0001_0000;
                2:       maxp_word = 32'h0001_FFFF;
                3:       maxp_word = 32'd0;
                default: maxp_word = $urandom_range(2, 12);
            endcase
            // wide box and plenty of slots so the long output stall fills the block
            if (ph == 6) begin
                for (int a = 0; a < 3; a++) begin
                    lo[a] = int'(INT_MIN_W);
                    hi[a] = int'(INT_MAX_W);
                end
                maxp_word = 32'h0001_0000;
            end
            load_settings(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], thr_word, maxp_word);
            src_idle_pct = (ph < 3) ? 33 : (ph < 6) ? 46 : 0;
            snk_idle_pct = (ph < 3) ? 46 : (ph < 6) ? 33 : 0;

            for (int chunk = 0; chunk < 3; chunk++) begin
                for (int n = 0; n < 40; n++) begin
                    first_pt = (cloud_left == 0);
                    if (first_pt) cloud_left = $urandom_range(1, 24);
                    cloud_left--;
                    roll = $urandom_range(9);
                    case (roll)
                        0:       inten = 16'd0;
                        1:       inten = 16'hFFFF;
                        2:       inten = thresh_reg;
                        3:       inten = thresh_reg - 1'b1;
                        4, 5:    inten = 16'($urandom_range(thresh_reg));
                        default: inten = 16'($urandom);
                    endcase
                    add_point(first_pt, pick_coord(lo[0], hi[0]), pick_coord(lo[1], hi[1]),
                              pick_coord(lo[2], hi[2]), ($urandom_range(99) < 7), inten);
                end
                // long output stall while the driver keeps offering
                if (ph == 6 && chunk == 0) hold_req <= hold_req + 1;
                // sender pause until every kept point is out
                if ((ph == 6 && chunk == 1) || $urandom_range(2) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0 && kept_queue.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pcbf_pkg.sv
rtl/core/pcbf_ctrl.sv
rtl/core/pcbf_datapath.sv
rtl/core/point_crop_box_filter.sv
rtl/core/pcbf_checker.sv
sim/point_crop_box_filter_tb.sv
